@@ sv/rlg_pkg.sv @@
`timescale 1ns / 1ps

package rlg_pkg;

	// default client count, ids 1 .. NUM_CLIENTS-1 are valid
	localparam int NUM_CLIENTS_DEF = 4;

	localparam int GEN_W    = 32;
	localparam int PARK_W   = 16;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;
	localparam int PHASE_W  = 2;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_CLAIM  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

	// guard phases
	localparam logic [PHASE_W-1:0] PH_IDLE      = 2'd0;
	localparam logic [PHASE_W-1:0] PH_ACTIVE    = 2'd1;
	localparam logic [PHASE_W-1:0] PH_RELEASING = 2'd2;
	localparam logic [PHASE_W-1:0] PH_POISONED  = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SHUTDOWN = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_STALE    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_POISONED = 3'd6;
	localparam logic [STATUS_W-1:0] ST_PARKFAIL = 3'd7;

	// reported when the stored poison code is not negative (-5, i/o error)
	localparam logic [PARK_W-1:0] EIO_CODE = 16'hFFFB;

	// result fields shared by every client width
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [GEN_W-1:0]    granted;
		logic [PARK_W-1:0]   err;
		logic [PHASE_W-1:0]  phase;
	} rlg_result_t;

endpackage

@@ sv/rlg_core.sv @@
`timescale 1ns / 1ps

module rlg_core #(
	parameter int NUM_CLIENTS = rlg_pkg::NUM_CLIENTS_DEF,
	parameter int CLIENT_W    = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        paused,
	input  logic [rlg_pkg::KIND_W-1:0]  kind,
	input  logic [CLIENT_W-1:0]         client,
	input  logic [rlg_pkg::GEN_W-1:0]   gen,
	input  logic [rlg_pkg::PARK_W-1:0]  park,
	output rlg_pkg::rlg_result_t        result,
	output logic [CLIENT_W-1:0]         owner
);

	localparam logic [CLIENT_W:0] CLIENT_LIM = (CLIENT_W+1)'(NUM_CLIENTS);

	logic [rlg_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [rlg_pkg::GEN_W-1:0]   owner_gen_q, owner_gen_d;
	logic [CLIENT_W-1:0]         owner_client_q, owner_client_d;
	logic [rlg_pkg::GEN_W-1:0]   counter_q, counter_d;
	logic [rlg_pkg::PARK_W-1:0]  poison_q, poison_d;

	logic                        client_ok;
	logic                        gen_zero;
	logic                        lease_match;
	logic [rlg_pkg::GEN_W-1:0]   counter_inc;
	logic [rlg_pkg::GEN_W-1:0]   next_gen;
	logic [rlg_pkg::PARK_W-1:0]  poison_rep;
	logic [rlg_pkg::STATUS_W-1:0] status;
	logic [rlg_pkg::GEN_W-1:0]   granted;
	logic [rlg_pkg::PARK_W-1:0]  err;

	// request checks against the current lease
	assign client_ok   = (client != '0) && ({1'b0, client} < CLIENT_LIM);
	assign gen_zero    = (gen == '0);
	assign lease_match = !gen_zero && (owner_gen_q == gen) && (owner_client_q == client);
	assign counter_inc = counter_q + rlg_pkg::GEN_W'(1);
	assign next_gen    = (counter_inc == '0) ? rlg_pkg::GEN_W'(1) : counter_inc;
	assign poison_rep  = poison_q[rlg_pkg::PARK_W-1] ? poison_q : rlg_pkg::EIO_CODE;

	// phase decisions and next state
	always_comb begin
		phase_d        = phase_q;
		owner_gen_d    = owner_gen_q;
		owner_client_d = owner_client_q;
		counter_d      = counter_q;
		poison_d       = poison_q;
		status         = rlg_pkg::ST_INVALID;
		granted        = '0;
		err            = '0;
		unique case (kind)
			rlg_pkg::KIND_CLAIM: begin
				if (!client_ok) begin
					status = rlg_pkg::ST_INVALID;
				end else if (paused) begin
					status = rlg_pkg::ST_SHUTDOWN;
				end else if (phase_q == rlg_pkg::PH_POISONED) begin
					status = rlg_pkg::ST_POISONED;
					err    = poison_rep;
				end else if (phase_q != rlg_pkg::PH_IDLE) begin
					status = rlg_pkg::ST_BUSY;
				end else begin
					counter_d      = next_gen;
					owner_gen_d    = next_gen;
					owner_client_d = client;
					phase_d        = rlg_pkg::PH_ACTIVE;
					granted        = next_gen;
					status         = rlg_pkg::ST_OK;
				end
			end
			rlg_pkg::KIND_BEGIN: begin
				if (!client_ok || gen_zero) begin
					status = rlg_pkg::ST_INVALID;
				end else if (!lease_match) begin
					status = rlg_pkg::ST_STALE;
				end else if (phase_q == rlg_pkg::PH_ACTIVE) begin
					phase_d = rlg_pkg::PH_RELEASING;
					status  = rlg_pkg::ST_OK;
				end else if (phase_q == rlg_pkg::PH_RELEASING) begin
					status = rlg_pkg::ST_ALREADY;
				end else if (phase_q == rlg_pkg::PH_POISONED) begin
					status = rlg_pkg::ST_POISONED;
					err    = poison_rep;
				end else begin
					status = rlg_pkg::ST_STALE;
				end
			end
			rlg_pkg::KIND_FINISH: begin
				if (!client_ok || gen_zero) begin
					status = rlg_pkg::ST_INVALID;
				end else if (!lease_match) begin
					status = rlg_pkg::ST_STALE;
				end else if (phase_q != rlg_pkg::PH_RELEASING) begin
					if (phase_q == rlg_pkg::PH_POISONED && poison_q[rlg_pkg::PARK_W-1]) begin
						status = rlg_pkg::ST_POISONED;
						err    = poison_q;
					end else begin
						status = rlg_pkg::ST_ALREADY;
					end
				end else if (park[rlg_pkg::PARK_W-1]) begin
					phase_d  = rlg_pkg::PH_POISONED;
					poison_d = park;
					status   = rlg_pkg::ST_PARKFAIL;
					err      = park;
				end else begin
					phase_d        = rlg_pkg::PH_IDLE;
					owner_gen_d    = '0;
					owner_client_d = '0;
					poison_d       = '0;
					status         = rlg_pkg::ST_OK;
				end
			end
			default: begin
				status = rlg_pkg::ST_INVALID;
			end
		endcase
	end

	// result seen after this request
	assign result.status  = status;
	assign result.granted = granted;
	assign result.err     = err;
	assign result.phase   = phase_d;
	assign owner          = (phase_d == rlg_pkg::PH_IDLE) ? '0 : owner_client_d;

	// guard state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= rlg_pkg::PH_IDLE;
			owner_gen_q    <= '0;
			owner_client_q <= '0;
			counter_q      <= '0;
			poison_q       <= '0;
		end else if (fire) begin
			phase_q        <= phase_d;
			owner_gen_q    <= owner_gen_d;
			owner_client_q <= owner_client_d;
			counter_q      <= counter_d;
			poison_q       <= poison_d;
		end
	end

endmodule

@@ sv/radio_lease_guard_unit.sv @@
`timescale 1ns / 1ps

// Exclusive lease guard for one shared radio resource.
// Requests enter on the s_* stream: s_tuser carries the kind (claim,
// release begin, release finish), s_tdata the client id, the lease
// generation and the parking result. Every request gives exactly one
// result on the m_* stream: m_tuser carries the status, m_tdata the
// granted generation, the error value, the phase and the owner after it.
// The cfg_* channel writes the admission pause bit; write it only while
// no request is in flight.
// The request lands in the input register; when the result register is
// free or being read, the decision logic and the guard state update
// load the result register. One request is accepted per cycle unless
// the receiver stalls with both registers full, set by the state update
// loop through the guard state registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; s_tready drops only when both
// are full.
// Reset clears the guard to idle with no owner, generation counter and
// poison code at zero, admission open, and both registers empty.
module radio_lease_guard_unit #(
	parameter int NUM_CLIENTS = rlg_pkg::NUM_CLIENTS_DEF,
	localparam int CLIENT_W  = $clog2(NUM_CLIENTS),
	localparam int IN_BITS   = CLIENT_W + rlg_pkg::GEN_W + rlg_pkg::PARK_W,
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS  = rlg_pkg::GEN_W + rlg_pkg::PARK_W + rlg_pkg::PHASE_W + CLIENT_W,
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// client_id, lease_generation, park_code, zero fill
	input  logic [IN_W-1:0]                s_tdata,
	// kind
	input  logic [rlg_pkg::KIND_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// granted_generation, error_value, phase_now, owner_now, zero fill
	output logic [OUT_W-1:0]               m_tdata,
	// status
	output logic [rlg_pkg::STATUS_W-1:0]   m_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data
);

	localparam int GEN_LO  = CLIENT_W;
	localparam int PARK_LO = CLIENT_W + rlg_pkg::GEN_W;

	logic                          paused_q;
	logic                          valid_s1;
	logic [rlg_pkg::KIND_W-1:0]    kind_s1;
	logic [CLIENT_W-1:0]           client_s1;
	logic [rlg_pkg::GEN_W-1:0]     gen_s1;
	logic [rlg_pkg::PARK_W-1:0]    park_s1;
	logic                          out_valid_q;
	rlg_pkg::rlg_result_t          result_q;
	logic [CLIENT_W-1:0]           owner_q;
	rlg_pkg::rlg_result_t          result;
	logic [CLIENT_W-1:0]           owner;
	logic                          advance;
	logic                          fire;
	logic                          take;

	// handshake
	assign advance   = !out_valid_q || m_tready;
	assign fire      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign take      = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// admission pause register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q <= 1'b0;
		end else if (cfg_valid) begin
			paused_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1   <= s_tuser;
			client_s1 <= s_tdata[CLIENT_W-1:0];
			gen_s1    <= s_tdata[GEN_LO +: rlg_pkg::GEN_W];
			park_s1   <= s_tdata[PARK_LO +: rlg_pkg::PARK_W];
		end
	end

	rlg_core #(
		.NUM_CLIENTS (NUM_CLIENTS),
		.CLIENT_W    (CLIENT_W)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.paused (paused_q),
		.kind   (kind_s1),
		.client (client_s1),
		.gen    (gen_s1),
		.park   (park_s1),
		.result (result),
		.owner  (owner)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
			owner_q  <= owner;
		end
	end

	// output packing
	assign m_tvalid = out_valid_q;
	assign m_tuser  = result_q.status;
	assign m_tdata  = OUT_W'({owner_q, result_q.phase, result_q.err, result_q.granted});

	// s_tready drops only with both registers full and the receiver stalled
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled while a register was free");

	// a request that fires from the input register reaches the output on the next edge
	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("request lost between input and result register");

	// an idle guard reports no owner
	a_idle_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.phase == rlg_pkg::PH_IDLE) |-> (owner_q == '0))
		else $error("owner reported while idle");

	// only a granted claim carries a generation, and it is never zero
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.granted != '0) |->
		(result_q.status == rlg_pkg::ST_OK && result_q.phase == rlg_pkg::PH_ACTIVE))
		else $error("generation granted without a successful claim");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int NUM_CLIENTS = rlg_pkg::NUM_CLIENTS_DEF;
	localparam int IN_W = 56;
	localparam int OUT_W = 56;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int OPEN_ITEMS = 140;
	localparam int PAUSED_ITEMS = 25;
	localparam int N_DIRECTED = 18;

	// kind code with no meaning, must come back invalid
	localparam logic [rlg_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [rlg_pkg::STATUS_W-1:0] status;
		logic [rlg_pkg::GEN_W-1:0]    granted;
		logic [rlg_pkg::PARK_W-1:0]   err;
		logic [rlg_pkg::PHASE_W-1:0]  phase;
		logic [1:0]                   owner;
	} lease_result_t;

	typedef struct packed {
		logic [rlg_pkg::KIND_W-1:0] kind;
		logic [1:0]                 client;
		logic [rlg_pkg::GEN_W-1:0]  gen;
		logic [rlg_pkg::PARK_W-1:0] park;
		logic                       typed;
		lease_result_t              res;
	} lease_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic [rlg_pkg::KIND_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [rlg_pkg::STATUS_W-1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	// shadow copy of the guard state
	logic                         paused_shadow = 1'b0;
	logic [rlg_pkg::PHASE_W-1:0]  lease_phase = rlg_pkg::PH_IDLE;
	logic [rlg_pkg::GEN_W-1:0]    lease_gen = '0;
	logic [1:0]                   lease_owner = '0;
	logic [rlg_pkg::GEN_W-1:0]    gen_counter = '0;
	logic [rlg_pkg::PARK_W-1:0]   poison_held = '0;

	lease_result_t pending_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_len = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_cnt = 0;
	int fail_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int pause_writes = 0;
	int stall_cycles = 0;
	int poisoned_results = 0;
	int cycles = 0;
	lease_result_t got_res;
	lease_result_t want_res;

	radio_lease_guard_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// directed rows, typed results only where obvious
	lease_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{rlg_pkg::KIND_CLAIM, 2'd0, 32'd0, 16'd0, 1'b1,
			'{rlg_pkg::ST_INVALID, 32'd0, 16'd0, rlg_pkg::PH_IDLE, 2'd0}},
		'{KIND_UNUSED, 2'd1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
			'{rlg_pkg::ST_INVALID, 32'd0, 16'd0, rlg_pkg::PH_IDLE, 2'd0}},
		'{rlg_pkg::KIND_BEGIN, 2'd1, 32'd0, 16'd0, 1'b1,
			'{rlg_pkg::ST_INVALID, 32'd0, 16'd0, rlg_pkg::PH_IDLE, 2'd0}},
		'{rlg_pkg::KIND_FINISH, 2'd3, 32'd0, 16'h8000, 1'b1,
			'{rlg_pkg::ST_INVALID, 32'd0, 16'd0, rlg_pkg::PH_IDLE, 2'd0}},
		'{rlg_pkg::KIND_BEGIN, 2'd1, 32'd5, 16'd0, 1'b1,
			'{rlg_pkg::ST_STALE, 32'd0, 16'd0, rlg_pkg::PH_IDLE, 2'd0}},
		'{rlg_pkg::KIND_FINISH, 2'd2, 32'hFFFF_FFFF, 16'd0, 1'b1,
			'{rlg_pkg::ST_STALE, 32'd0, 16'd0, rlg_pkg::PH_IDLE, 2'd0}},
		'{rlg_pkg::KIND_CLAIM, 2'd1, 32'hFFFF_FFFF, 16'd0, 1'b1,
			'{rlg_pkg::ST_OK, 32'd1, 16'd0, rlg_pkg::PH_ACTIVE, 2'd1}},
		'{rlg_pkg::KIND_CLAIM, 2'd2, 32'd0, 16'd0, 1'b1,
			'{rlg_pkg::ST_BUSY, 32'd0, 16'd0, rlg_pkg::PH_ACTIVE, 2'd1}},
		'{rlg_pkg::KIND_FINISH, 2'd1, 32'd1, 16'd0, 1'b0, '0},
		'{rlg_pkg::KIND_BEGIN, 2'd2, 32'd1, 16'd0, 1'b0, '0},
		'{rlg_pkg::KIND_BEGIN, 2'd1, 32'd1, 16'd0, 1'b1,
			'{rlg_pkg::ST_OK, 32'd0, 16'd0, rlg_pkg::PH_RELEASING, 2'd1}},
		'{rlg_pkg::KIND_BEGIN, 2'd1, 32'd1, 16'd0, 1'b0, '0},
		'{rlg_pkg::KIND_CLAIM, 2'd3, 32'd0, 16'd0, 1'b1,
			'{rlg_pkg::ST_BUSY, 32'd0, 16'd0, rlg_pkg::PH_RELEASING, 2'd1}},
		'{rlg_pkg::KIND_FINISH, 2'd1, 32'd2, 16'd0, 1'b0, '0},
		'{rlg_pkg::KIND_FINISH, 2'd1, 32'd1, 16'd0, 1'b1,
			'{rlg_pkg::ST_OK, 32'd0, 16'd0, rlg_pkg::PH_IDLE, 2'd0}},
		'{rlg_pkg::KIND_CLAIM, 2'd3, 32'd0, 16'd0, 1'b1,
			'{rlg_pkg::ST_OK, 32'd2, 16'd0, rlg_pkg::PH_ACTIVE, 2'd3}},
		'{rlg_pkg::KIND_BEGIN, 2'd3, 32'd2, 16'd0, 1'b0, '0},
		'{rlg_pkg::KIND_FINISH, 2'd3, 32'd2, 16'h7FFF, 1'b1,
			'{rlg_pkg::ST_OK, 32'd0, 16'd0, rlg_pkg::PH_IDLE, 2'd0}}
	};

	// one guard decision, updates the shadow state
	function automatic lease_result_t guard_decide(input logic [rlg_pkg::KIND_W-1:0] k,
			input logic [1:0] c, input logic [rlg_pkg::GEN_W-1:0] g,
			input logic [rlg_pkg::PARK_W-1:0] p);
		lease_result_t r;
		logic client_valid;
		logic same_lease;
		logic [rlg_pkg::PARK_W-1:0] poison_shown;
		r = '0;
		r.status = rlg_pkg::ST_INVALID;
		client_valid = (c != 2'd0) && (int'(c) < NUM_CLIENTS);
		same_lease = (g != '0) && (lease_gen == g) && (lease_owner == c);
		poison_shown = poison_held[rlg_pkg::PARK_W-1] ? poison_held : rlg_pkg::EIO_CODE;
		case (k)
			rlg_pkg::KIND_CLAIM: begin
				if (!client_valid) begin
					r.status = rlg_pkg::ST_INVALID;
				end else if (paused_shadow) begin
					r.status = rlg_pkg::ST_SHUTDOWN;
				end else if (lease_phase == rlg_pkg::PH_POISONED) begin
					r.status = rlg_pkg::ST_POISONED;
					r.err = poison_shown;
				end else if (lease_phase != rlg_pkg::PH_IDLE) begin
					r.status = rlg_pkg::ST_BUSY;
				end else begin
					gen_counter = gen_counter + 1;
					if (gen_counter == '0)
						gen_counter = 1;
					lease_gen = gen_counter;
					lease_owner = c;
					lease_phase = rlg_pkg::PH_ACTIVE;
					r.granted = gen_counter;
					r.status = rlg_pkg::ST_OK;
				end
			end
			rlg_pkg::KIND_BEGIN: begin
				if (!client_valid || g == '0) begin
					r.status = rlg_pkg::ST_INVALID;
				end else if (!same_lease) begin
					r.status = rlg_pkg::ST_STALE;
				end else if (lease_phase == rlg_pkg::PH_ACTIVE) begin
					lease_phase = rlg_pkg::PH_RELEASING;
					r.status = rlg_pkg::ST_OK;
				end else if (lease_phase == rlg_pkg::PH_RELEASING) begin
					r.status = rlg_pkg::ST_ALREADY;
				end else if (lease_phase == rlg_pkg::PH_POISONED) begin
					r.status = rlg_pkg::ST_POISONED;
					r.err = poison_shown;
				end else begin
					r.status = rlg_pkg::ST_STALE;
				end
			end
			rlg_pkg::KIND_FINISH: begin
				if (!client_valid || g == '0) begin
					r.status = rlg_pkg::ST_INVALID;
				end else if (!same_lease) begin
					r.status = rlg_pkg::ST_STALE;
				end else if (lease_phase != rlg_pkg::PH_RELEASING) begin
					if (lease_phase == rlg_pkg::PH_POISONED
							&& poison_held[rlg_pkg::PARK_W-1]) begin
						r.status = rlg_pkg::ST_POISONED;
						r.err = poison_held;
					end else begin
						r.status = rlg_pkg::ST_ALREADY;
					end
				end else if (p[rlg_pkg::PARK_W-1]) begin
					// failed park: guard stays owned and is dead until reset
					lease_phase = rlg_pkg::PH_POISONED;
					poison_held = p;
					r.status = rlg_pkg::ST_PARKFAIL;
					r.err = p;
				end else begin
					lease_phase = rlg_pkg::PH_IDLE;
					lease_gen = '0;
					lease_owner = '0;
					poison_held = '0;
					r.status = rlg_pkg::ST_OK;
				end
			end
			default: r.status = rlg_pkg::ST_INVALID;
		endcase
		r.phase = lease_phase;
		r.owner = (lease_phase == rlg_pkg::PH_IDLE) ? 2'd0 : lease_owner;
		return r;
	endfunction

	// offer one request, record its expected result on acceptance
	task automatic send_request(input logic [rlg_pkg::KIND_W-1:0] k, input logic [1:0] c,
			input logic [rlg_pkg::GEN_W-1:0] g, input logic [rlg_pkg::PARK_W-1:0] p,
			input logic typed = 1'b0, input lease_result_t typed_res = '0);
		lease_result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {6'd0, p, g, c};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		r = guard_decide(k, c, g, p);
		if (typed)
			r = typed_res;
		pending_results.push_back(r);
		requests_sent++;
	endtask

	// a request shaped by the current lease, with some noise mixed in
	task automatic send_random_item(input logic may_poison);
		logic [rlg_pkg::KIND_W-1:0] k;
		logic [1:0] c;
		logic [rlg_pkg::GEN_W-1:0] g;
		logic [rlg_pkg::PARK_W-1:0] p;
		logic [31:0] rnd;
		int pick;
		pick = $urandom_range(99);
		c = 2'($urandom_range(1, NUM_CLIENTS - 1));
		g = lease_gen;
		p = may_poison ? 16'($urandom_range(32768, 65535)) : 16'($urandom_range(0, 32767));
		k = rlg_pkg::KIND_CLAIM;
		if (pick < 15) begin
			// noise: generation zero or far above any granted one, never matches
			rnd = $urandom;
			k = 2'($urandom_range(0, 3));
			c = 2'($urandom_range(0, 3));
			g = ($urandom_range(9) == 0) ? '0 : {1'b1, rnd[30:0]};
			p = 16'($urandom);
		end else begin
			pick = $urandom_range(99);
			case (lease_phase)
				rlg_pkg::PH_IDLE: begin
					if (pick >= 90)
						c = 2'd0;
				end
				rlg_pkg::PH_ACTIVE: begin
					if (pick < 65) begin
						k = rlg_pkg::KIND_BEGIN;
						c = lease_owner;
					end else if (pick < 85) begin
						k = rlg_pkg::KIND_BEGIN;
						g = (pick < 75) ? lease_gen : lease_gen + 1;
					end else if (pick >= 92) begin
						k = rlg_pkg::KIND_FINISH;
						c = lease_owner;
					end
				end
				rlg_pkg::PH_RELEASING: begin
					if (pick < 70) begin
						k = rlg_pkg::KIND_FINISH;
						c = lease_owner;
					end else if (pick < 80) begin
						k = rlg_pkg::KIND_BEGIN;
						c = lease_owner;
					end else if (pick >= 90) begin
						k = rlg_pkg::KIND_FINISH;
						c = lease_owner;
						g = lease_gen ^ 32'd1;
					end
				end
				default: begin
					k = 2'($urandom_range(0, 2));
					if (pick < 70)
						c = lease_owner;
				end
			endcase
		end
		send_request(k, c, g, p);
	endtask

	// stop offering and let every pending result come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pause(input logic v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		paused_shadow = v;
		pause_writes++;
		cfg_valid <= 1'b0;
	endtask

	// result check and receiver back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_res = '{m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[49:48],
					m_tdata[51:50]};
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: st %0d gen %0h err %0h ph %0d own %0d",
							got_res.status, got_res.granted, got_res.err, got_res.phase,
							got_res.owner);
				end else begin
					want_res = pending_results.pop_front();
					results_checked++;
					if (want_res.status == rlg_pkg::ST_POISONED)
						poisoned_results++;
					if (got_res.status !== want_res.status
							|| got_res.granted !== want_res.granted
							|| got_res.err !== want_res.err
							|| got_res.phase !== want_res.phase
							|| got_res.owner !== want_res.owner) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result %0d exp st %0d gen %0h err %0h ph %0d own %0d",
								results_checked, want_res.status, want_res.granted,
								want_res.err, want_res.phase, want_res.owner);
							$display("result %0d got st %0d gen %0h err %0h ph %0d own %0d",
								results_checked, got_res.status, got_res.granted,
								got_res.err, got_res.phase, got_res.owner);
						end
					end
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_cnt = hold_len;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// cycle limit and input stall count
	always @(posedge clk) begin
		cycles++;
		if (s_tvalid && !s_tready && arst_n)
			stall_cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_pause(1'b0);

		// directed table
		for (int i = 0; i < N_DIRECTED; i++)
			send_request(directed_rows[i].kind, directed_rows[i].client,
				directed_rows[i].gen, directed_rows[i].park,
				directed_rows[i].typed, directed_rows[i].res);
		wait_for_results();

		// three idle patterns, each with an admission pause in the middle
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 60 : 0;
			recv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 25 : 0;
			if (mode == 2) begin
				// long receiver hold while the sender keeps pushing
				hold_len = HOLD_OFF_CYCLES;
				hold_req <= hold_req + 1;
				repeat (12) send_random_item(1'b0);
			end
			repeat (OPEN_ITEMS / 2) send_random_item(1'b0);
			wait_for_results();
			write_pause(1'b1);
			repeat (PAUSED_ITEMS) send_random_item(1'b0);
			wait_for_results();
			write_pause(1'b0);
			repeat (OPEN_ITEMS / 2) send_random_item(1'b0);
			wait_for_results();
		end

		// poisoning is permanent, so the failed park comes last
		send_idle_pct = 25;
		recv_idle_pct = 25;
		while (lease_phase != rlg_pkg::PH_POISONED)
			send_random_item(1'b1);
		repeat (20) send_random_item(1'b1);
		wait_for_results();
		write_pause(1'b1);
		send_request(rlg_pkg::KIND_CLAIM, 2'd1, 32'd0, 16'd0);
		send_request(rlg_pkg::KIND_CLAIM, 2'd0, 32'd0, 16'd0);
		send_request(rlg_pkg::KIND_FINISH, lease_owner, lease_gen, 16'd0);
		send_request(rlg_pkg::KIND_BEGIN, lease_owner, lease_gen, 16'd0);
		wait_for_results();

		$display("covered %0d requests and %0d results, %0d pause writes, ending poisoned",
			requests_sent, results_checked, pause_writes);
		$display("input held back %0d cycles, %0d poisoned refusals, %0d mismatches",
			stall_cycles, poisoned_results, fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
